>>> sv/ftbm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftbm_pkg
// Shared constants, types and the build-time sine table of the FSK tape byte
// modulator.
// ----------------------------------------------------------------------------
package ftbm_pkg;

   localparam int PHASE_BITS    = 16;
   localparam int SINE_DEPTH    = 256;
   localparam int IDX_W         = $clog2(SINE_DEPTH);
   localparam int STEP_W        = 15;
   localparam int AMP_W         = 15;
   localparam int SPB_W         = 7;
   localparam int POS_W         = 4;
   localparam int SAMPLE_W      = 16;
   localparam int MAG_W         = 15;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_MARK_STEP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACE_STEP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPB        = 2'd3;

   localparam logic [STEP_W-1:0] RESET_MARK_STEP  = 15'd7916;
   localparam logic [STEP_W-1:0] RESET_SPACE_STEP = 15'd5937;
   localparam logic [AMP_W-1:0]  RESET_AMPLITUDE  = 15'd16384;
   localparam logic [SPB_W-1:0]  RESET_SPB        = 7'd74;

   localparam logic [POS_W-1:0] POS_START = 4'd0;
   localparam logic [POS_W-1:0] POS_STOP  = 4'd9;

   localparam logic [63:0] Q30_ONE  = 64'd1073741824;
   localparam logic [63:0] Q30_HALF = 64'd536870912;
   localparam logic [63:0] SINE_MAX = 64'd32767;

   typedef logic [SINE_DEPTH-1:0][SAMPLE_W-1:0] sine_tab_type;

   typedef struct packed {
      logic tone;
      logic accepted;
      logic busy;
      logic frame_end;
   } frame_stat_type;

   function automatic logic [63:0] q30_mul(logic [63:0] a, logic [63:0] b);
      logic [63:0] p;
      p = a * b;
      return p >> 30;
   endfunction

   function automatic logic [SAMPLE_W-1:0] sine_entry(int unsigned k);
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] acc;
      logic [63:0] s;
      logic [63:0] v;
      q = 64'(4 * k) / 64'(SINE_DEPTH);
      r = 64'(4 * k) % 64'(SINE_DEPTH);
      t = (r << 30) / 64'(SINE_DEPTH);
      if (q[0]) begin
         t = Q30_ONE - t;
      end
      t2  = q30_mul(t, t);
      acc = 64'd172272;
      acc = 64'd5026997 - q30_mul(t2, acc);
      acc = 64'd85569306 - q30_mul(t2, acc);
      acc = 64'd693598669 - q30_mul(t2, acc);
      acc = 64'd1686629713 - q30_mul(t2, acc);
      s   = q30_mul(t, acc);
      v   = (s * SINE_MAX + Q30_HALF) >> 30;
      if (v > SINE_MAX) begin
         v = SINE_MAX;
      end
      if (q >= 64'd2) begin
         v = -v;
      end
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic sine_tab_type build_sine_tab();
      sine_tab_type tab;
      for (int unsigned k = 0; k < SINE_DEPTH; k++) begin
         tab[k] = sine_entry(k);
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

endpackage
`default_nettype wire

>>> sv/ftbm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftbm channel interfaces
// Valid/ready channels for tick requests and sample responses.
// ----------------------------------------------------------------------------
interface ftbm_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] data_byte;

   modport source (output valid, output opcode, output data_byte, input ready);
   modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface ftbm_rsp_if;
   import ftbm_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       tone;
   logic                       byte_accepted;
   logic                       busy_res;
   logic                       frame_end;

   modport source (output valid, output sample, output tone, output byte_accepted,
                   output busy_res, output frame_end, input ready);
   modport sink   (input valid, input sample, input tone, input byte_accepted,
                   input busy_res, input frame_end, output ready);
endinterface
`default_nettype wire

>>> sv/ftbm_frame_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftbm_frame_ctrl
// Byte framing sequencer and continuous-phase accumulator, one step per tick.
// ----------------------------------------------------------------------------
module ftbm_frame_ctrl (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  step,
   input  wire                                  opcode,
   input  wire  [7:0]                           data_byte,
   input  wire  [ftbm_pkg::STEP_W-1:0]          mark_step,
   input  wire  [ftbm_pkg::STEP_W-1:0]          space_step,
   input  wire  [ftbm_pkg::SPB_W-1:0]           samples_per_bit,
   output ftbm_pkg::frame_stat_type             stat,
   output logic [ftbm_pkg::PHASE_BITS-1:0]      phase_next
);
   import ftbm_pkg::*;

   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [SPB_W-1:0]      count_ff, count_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [7:0]            bits_ff, bits_in;
   logic                  active_ff, active_in;

   logic                  accept;
   logic                  act;
   logic [7:0]            bits_cur;
   logic [POS_W-1:0]      pos_cur;
   logic [POS_W-1:0]      pos_m1;
   logic [SPB_W-1:0]      count_cur;
   logic [SPB_W-1:0]      count_inc;
   logic [SPB_W-1:0]      spb;
   logic                  tone;
   logic                  fend;

   always_comb begin
      accept    = opcode && !active_ff;
      act       = active_ff || accept;
      bits_cur  = accept ? ~data_byte : bits_ff;
      pos_cur   = accept ? POS_START : pos_ff;
      count_cur = accept ? '0 : count_ff;
      pos_m1    = pos_cur - 1'b1;

      if (!act) begin
         tone = 1'b0;
      end else if (pos_cur == POS_START) begin
         tone = 1'b1;
      end else if (pos_cur < POS_STOP) begin
         tone = !bits_cur[pos_m1[2:0]];
      end else begin
         tone = 1'b0;
      end

      phase_in  = phase_ff + PHASE_BITS'(tone ? space_step : mark_step);
      spb       = (samples_per_bit == '0) ? SPB_W'(1) : samples_per_bit;
      count_inc = count_cur + 1'b1;

      count_in  = count_cur;
      pos_in    = pos_cur;
      bits_in   = bits_cur;
      active_in = act;
      fend      = 1'b0;
      if (act) begin
         count_in = count_inc;
         if (count_inc >= spb) begin
            count_in = '0;
            if (pos_cur >= POS_STOP) begin
               fend      = 1'b1;
               active_in = 1'b0;
               pos_in    = POS_START;
            end else begin
               pos_in = pos_cur + 1'b1;
            end
         end
      end

      stat.tone      = tone;
      stat.accepted  = accept;
      stat.busy      = active_in;
      stat.frame_end = fend;
      phase_next     = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         count_ff  <= '0;
         pos_ff    <= POS_START;
         bits_ff   <= '0;
         active_ff <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         pos_ff    <= pos_in;
         bits_ff   <= bits_in;
         active_ff <= active_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/ftbm_sine_amp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftbm_sine_amp
// Sine table lookup and amplitude scaling, truncated toward zero.
// ----------------------------------------------------------------------------
module ftbm_sine_amp (
   input  wire  [ftbm_pkg::PHASE_BITS-1:0]      phase,
   input  wire  [ftbm_pkg::AMP_W-1:0]           amplitude,
   output logic signed [ftbm_pkg::SAMPLE_W-1:0] sample
);
   import ftbm_pkg::*;

   localparam int PROD_W = AMP_W + MAG_W;

   logic [IDX_W-1:0]    idx;
   logic [SAMPLE_W-1:0] tv;
   logic                neg;
   logic [MAG_W-1:0]    abs_tv;
   logic [PROD_W-1:0]   prod;
   logic [PROD_W:0]     adj;
   logic [MAG_W-1:0]    mag;

   always_comb begin
      idx    = phase[PHASE_BITS-1 -: IDX_W];
      tv     = SINE_TAB[idx];
      neg    = tv[SAMPLE_W-1];
      abs_tv = neg ? MAG_W'(-tv) : tv[MAG_W-1:0];
      prod   = PROD_W'(amplitude) * PROD_W'(abs_tv);
      // divide by 2^15-1 via shift-add, exact for products below 2^30
      adj    = (PROD_W+1)'(prod) + (PROD_W+1)'(prod >> MAG_W) + 1'b1;
      mag    = adj[MAG_W +: MAG_W];
      sample = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

endmodule
`default_nettype wire

>>> sv/fsk_tape_byte_modulator_core.sv
`default_nettype none
// request held in the input register until the response register is free
// throughput: one tick per cycle while the response channel is not stalled
// reset: synchronous, clears phase, frame state and both pipeline valid flags,
// loads mark step 7916, space step 5937, amplitude 16384, 74 samples per bit
// ----------------------------------------------------------------------------
// fsk_tape_byte_modulator_core
// Continuous-phase FSK modulator sending bytes in a start/8 data/stop frame.
// ----------------------------------------------------------------------------
module fsk_tape_byte_modulator_core (
   input  wire                              clock,
   input  wire                              reset,
   ftbm_req_if.sink                         req_chan,
   ftbm_rsp_if.source                       rsp_chan,
   input  wire                              csr_wr_en,
   input  wire  [ftbm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [ftbm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ftbm_pkg::*;

   logic [STEP_W-1:0] mark_step_ff;
   logic [STEP_W-1:0] space_step_ff;
   logic [AMP_W-1:0]  amplitude_ff;
   logic [SPB_W-1:0]  spb_ff;

   logic       in_valid_ff, in_valid_in;
   logic       in_opcode_ff;
   logic [7:0] in_byte_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   frame_stat_type             rsp_stat_ff;

   logic                       req_xfer;
   logic                       out_free;
   logic                       advance;
   frame_stat_type             stat;
   logic [PHASE_BITS-1:0]      phase_next;
   logic signed [SAMPLE_W-1:0] sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_step_ff  <= RESET_MARK_STEP;
         space_step_ff <= RESET_SPACE_STEP;
         amplitude_ff  <= RESET_AMPLITUDE;
         spb_ff        <= RESET_SPB;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MARK_STEP:  mark_step_ff  <= csr_wdata[STEP_W-1:0];
            CSR_SPACE_STEP: space_step_ff <= csr_wdata[STEP_W-1:0];
            CSR_AMPLITUDE:  amplitude_ff  <= csr_wdata[AMP_W-1:0];
            CSR_SPB:        spb_ff        <= csr_wdata[SPB_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      out_free       = !rsp_valid_ff || rsp_chan.ready;
      advance        = in_valid_ff && out_free;
      req_chan.ready = !in_valid_ff || out_free;
      req_xfer       = req_chan.valid && req_chan.ready;
      in_valid_in    = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in   = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_opcode_ff <= req_chan.opcode;
         in_byte_ff   <= req_chan.data_byte;
      end
      if (advance) begin
         rsp_sample_ff <= sample;
         rsp_stat_ff   <= stat;
      end
   end

   ftbm_frame_ctrl u_frame_ctrl (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .opcode          (in_opcode_ff),
      .data_byte       (in_byte_ff),
      .mark_step       (mark_step_ff),
      .space_step      (space_step_ff),
      .samples_per_bit (spb_ff),
      .stat            (stat),
      .phase_next      (phase_next)
   );

   ftbm_sine_amp u_sine_amp (
      .phase     (phase_next),
      .amplitude (amplitude_ff),
      .sample    (sample)
   );

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.sample        = rsp_sample_ff;
   assign rsp_chan.tone          = rsp_stat_ff.tone;
   assign rsp_chan.byte_accepted = rsp_stat_ff.accepted;
   assign rsp_chan.busy_res      = rsp_stat_ff.busy;
   assign rsp_chan.frame_end     = rsp_stat_ff.frame_end;

   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.frame_end |-> !rsp_chan.busy_res && !rsp_chan.tone)
      else $error("frame end while still busy or on space tone");

   a_start_space: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.byte_accepted |-> rsp_chan.tone && rsp_chan.busy_res)
      else $error("accepted byte did not begin with a busy space start bit");

   a_idle_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.busy_res |-> !rsp_chan.tone)
      else $error("space tone outside a running frame");

   a_step_moves: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_chan.valid)
      else $error("tick advanced without a response transfer pending");

endmodule
`default_nettype wire
